// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the numeric entity decoder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define NCE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("nce assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define NCE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("nce assertion failed");

`endif

// File: sv/nce_pkg.sv
// ----------------------------------------------------------------------------
// nce_pkg
// Types, character codes and helpers for the numeric entity decoder.
// ----------------------------------------------------------------------------
package nce_pkg;

    typedef enum logic [2:0] {
        PH_AMP,
        PH_HASH,
        PH_BASE,
        PH_HEX,
        PH_DLEAD,
        PH_DDIG,
        PH_FROZEN,
        PH_NONE
    } t_phase;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_DEC  = 2'd1,
        KIND_HEX  = 2'd2
    } t_kind;

    // Control for one accumulate step
    typedef struct packed {
        logic neg;
        logic sat;
        logic hex;
    } t_acc_ctl;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_digit;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_F_UP  = 8'h46;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_F_LO  = 8'h66;

    function automatic t_digit hex_digit(input logic [7:0] c);
        t_digit d;
        logic [7:0] t;
        d.ok  = 1'b1;
        d.val = 4'd0;
        t     = 8'd0;
        if (c >= CH_0 && c <= CH_9) begin
            t = c - CH_0;
        end else if (c >= CH_A_LO && c <= CH_F_LO) begin
            t = c - CH_A_LO + 8'd10;
        end else if (c >= CH_A_UP && c <= CH_F_UP) begin
            t = c - CH_A_UP + 8'd10;
        end else begin
            d.ok = 1'b0;
        end
        d.val = t[3:0];
        return d;
    endfunction

    function automatic logic is_dec_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

// File: sv/nce_char_if.sv
// ----------------------------------------------------------------------------
// nce_char_if
// Character channel: one byte per transfer, with an end-of-string mark.
// ----------------------------------------------------------------------------
interface nce_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// File: sv/nce_result_if.sv
// ----------------------------------------------------------------------------
// nce_result_if
// Result channel: decoded value, kind code and saturation flag.
// ----------------------------------------------------------------------------
interface nce_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic        [1:0]  kind;
    logic               overflow;

    modport source (output valid, output value, output kind, output overflow, input ready);
    modport sink   (input valid, input value, input kind, input overflow, output ready);
endinterface

// File: sv/nce_accum.sv
// ----------------------------------------------------------------------------
// nce_accum
// Saturating multiply-by-base and add-digit step for the magnitude.
// ----------------------------------------------------------------------------
module nce_accum #(
    parameter int VALUE_BITS = 32
) (
    input  logic [VALUE_BITS-1:0] i_acc,
    input  logic [3:0]            i_digit,
    input  nce_pkg::t_acc_ctl     i_ctl,
    output logic [VALUE_BITS-1:0] o_acc,
    output logic                  o_sat
);
    import nce_pkg::*;

    localparam int PW = VALUE_BITS + 5;

    logic [PW-1:0]         w_acc_ext;
    logic [PW-1:0]         w_scaled;
    logic [PW-1:0]         w_sum;
    logic [VALUE_BITS-1:0] w_lim;

    assign w_acc_ext = PW'(i_acc);
    // x16 is a shift, x10 is x8 + x2
    assign w_scaled  = i_ctl.hex ? (w_acc_ext << 4)
                                 : ((w_acc_ext << 3) + (w_acc_ext << 1));
    assign w_sum     = w_scaled + PW'(i_digit);
    assign w_lim     = i_ctl.neg ? {1'b1, {(VALUE_BITS-1){1'b0}}}
                                 : {1'b0, {(VALUE_BITS-1){1'b1}}};

    always_comb begin
        if (i_ctl.sat) begin
            o_acc = i_acc;
            o_sat = 1'b1;
        end else if (w_sum > PW'(w_lim)) begin
            o_acc = w_lim;
            o_sat = 1'b1;
        end else begin
            o_acc = w_sum[VALUE_BITS-1:0];
            o_sat = 1'b0;
        end
    end

endmodule

// File: sv/numeric_char_entity_parser_core.sv
// ----------------------------------------------------------------------------
// numeric_char_entity_parser_core
// Decodes numeric refs ("&#123;", "&#x7B;") one byte a cycle unless stalled.
// ----------------------------------------------------------------------------
//
//  channel    dir  payload                           transfer rule
//  ---------  ---  --------------------------------  ------------------------
//  i_char     in   char_code[7:0], last_char         valid & ready at edge
//  o_result   out  value[31:0] s, kind[1:0], ovfl    valid & ready at edge
//
//  One byte is taken per cycle unless a final byte stalls; there is no gap
//  between strings. A byte passes an input register, then a single step of
//  parse logic updates the parse state; a final byte then loads the result
//  register when that byte leaves the input register into the parse step.
//  Reset (synchronous, active low) returns the parser to expecting '&' and
//  empties both registers. A stalled result holds the result register; the
//  input register still drains non-final bytes, and a final byte waits
//  there until the result register frees.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module numeric_char_entity_parser_core #(
    parameter int VALUE_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    nce_char_if.sink      i_char,
    nce_result_if.source  o_result
);
    import nce_pkg::*;

    localparam int EXT_W = (VALUE_BITS > 32) ? VALUE_BITS : 32;

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_last;

    // Parse state
    t_phase                r_phase, n_phase, s_phase;
    t_kind                 r_kind,  n_kind,  s_kind;
    logic [VALUE_BITS-1:0] r_acc,   n_acc,   s_acc;
    logic                  r_neg,   n_neg,   s_neg;
    logic                  r_sat,   n_sat,   s_sat;

    // Result register
    logic               r_out_valid;
    logic signed [31:0] r_out_value;
    t_kind              r_out_kind;
    logic               r_out_overflow;

    logic                  w_in_fire;
    logic                  w_proc;
    logic                  w_out_free;
    logic                  w_use_acc;
    logic                  w_hex_step;
    t_digit                w_digit;
    t_acc_ctl              w_ctl;
    logic [VALUE_BITS-1:0] w_acc_step;
    logic                  w_sat_step;
    logic [EXT_W-1:0]      w_mag_ext;
    logic [EXT_W-1:0]      w_val_ext;
    logic                  w_lead;

    // Handshakes: the byte in the input register moves on unless it is a
    // final byte and the result register is still occupied.
    assign w_out_free   = !r_out_valid || o_result.ready;
    assign w_proc       = r_in_valid && (!r_in_last || w_out_free);
    assign i_char.ready = !r_in_valid || w_proc;
    assign w_in_fire    = i_char.valid && i_char.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_char.ready) begin
            r_in_valid <= i_char.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_in_char <= i_char.char_code;
            r_in_last <= i_char.last_char;
        end
    end

    // Parse step
    assign w_digit    = hex_digit(r_in_char);
    assign w_ctl.neg  = r_neg;
    assign w_ctl.sat  = r_sat;
    assign w_ctl.hex  = w_hex_step;
    assign w_lead     = (r_phase != PH_DDIG);

    nce_accum #(
        .VALUE_BITS (VALUE_BITS)
    ) u_accum (
        .i_acc   (r_acc),
        .i_digit (w_digit.val),
        .i_ctl   (w_ctl),
        .o_acc   (w_acc_step),
        .o_sat   (w_sat_step)
    );

    always_comb begin
        s_phase    = r_phase;
        s_kind     = r_kind;
        s_neg      = r_neg;
        w_use_acc  = 1'b0;
        w_hex_step = 1'b0;
        unique case (r_phase)
            PH_AMP: begin
                s_phase = (r_in_char == CH_AMP) ? PH_HASH : PH_NONE;
            end
            PH_HASH: begin
                if (r_in_char == CH_HASH) begin
                    s_phase = PH_BASE;
                    s_kind  = KIND_DEC;
                end else begin
                    s_phase = PH_NONE;
                end
            end
            PH_BASE, PH_DLEAD, PH_DDIG: begin
                // The base character is also the first decimal character
                priority if (r_phase == PH_BASE &&
                             (r_in_char == CH_X_LO || r_in_char == CH_X_UP)) begin
                    s_kind  = KIND_HEX;
                    s_phase = PH_HEX;
                end else if (is_dec_digit(r_in_char)) begin
                    w_use_acc = 1'b1;
                    s_phase   = PH_DDIG;
                end else if (w_lead && is_space(r_in_char)) begin
                    s_phase = PH_DLEAD;
                end else if (w_lead && (r_in_char == CH_PLUS || r_in_char == CH_MINUS)) begin
                    s_neg   = (r_in_char == CH_MINUS);
                    s_phase = PH_DDIG;
                end else begin
                    s_phase = PH_FROZEN;
                end
            end
            PH_HEX: begin
                if (w_digit.ok) begin
                    w_use_acc  = 1'b1;
                    w_hex_step = 1'b1;
                end else begin
                    s_phase = PH_FROZEN;
                end
            end
            PH_FROZEN, PH_NONE: begin
            end
            default: begin
            end
        endcase
    end

    assign s_acc = w_use_acc ? w_acc_step : r_acc;
    assign s_sat = w_use_acc ? w_sat_step : r_sat;

    // A final byte sends the parser back to its reset state
    always_comb begin
        if (r_in_last) begin
            n_phase = PH_AMP;
            n_kind  = KIND_NONE;
            n_acc   = '0;
            n_neg   = 1'b0;
            n_sat   = 1'b0;
        end else begin
            n_phase = s_phase;
            n_kind  = s_kind;
            n_acc   = s_acc;
            n_neg   = s_neg;
            n_sat   = s_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_AMP;
            r_kind  <= KIND_NONE;
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_sat   <= 1'b0;
        end else if (w_proc) begin
            r_phase <= n_phase;
            r_kind  <= n_kind;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_sat   <= n_sat;
        end
    end

    // Result: apply the sign at full width, keep the low 32 bits
    assign w_mag_ext = EXT_W'(s_acc);
    assign w_val_ext = s_neg ? (~w_mag_ext + EXT_W'(1)) : w_mag_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_proc && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc && r_in_last) begin
            r_out_kind <= s_kind;
            if (s_kind == KIND_NONE) begin
                r_out_value    <= '1;
                r_out_overflow <= 1'b0;
            end else begin
                r_out_value    <= w_val_ext[31:0];
                r_out_overflow <= s_sat;
            end
        end
    end

    assign o_result.valid    = r_out_valid;
    assign o_result.value    = r_out_value;
    assign o_result.kind     = r_out_kind;
    assign o_result.overflow = r_out_overflow;

    // Checks
    `NCE_ASSERT_NXT(a_last_resets, i_clk, i_rst_n, w_proc && r_in_last, r_phase == PH_AMP && r_acc == '0 && !r_neg && !r_sat)
    `NCE_ASSERT_IMP(a_none_is_minus_one, i_clk, i_rst_n, r_out_valid && r_out_kind == KIND_NONE, r_out_value == -32'sd1 && !r_out_overflow)
    `NCE_ASSERT_IMP(a_hex_positive, i_clk, i_rst_n, r_kind == KIND_HEX, !r_neg)
    `NCE_ASSERT_IMP(a_pos_bound, i_clk, i_rst_n, !r_neg, !r_acc[VALUE_BITS-1])
    `NCE_ASSERT_IMP(a_result_source, i_clk, i_rst_n, $rose(r_out_valid), $past(w_proc && r_in_last))

endmodule
